FILE: rtl/afc_pkg.sv
// Shared constants, types and class codes of the box frustum classifier.
`timescale 1ns / 1ps

package afc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COORD_W    = 24;
    localparam int COEF_W     = 14;
    localparam int OFS_W      = 22;
    localparam int REG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int B_LSB      = 14;
    localparam int C_LSB      = 28;
    localparam int D_LSB      = 42;
    localparam int OFS_SHIFT  = 12;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int AXES       = 3;

    typedef enum logic [1:0] {
        CLASS_OUTSIDE = 2'd0,
        CLASS_CUT     = 2'd1,
        CLASS_INSIDE  = 2'd2
    } t_box_class;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [OFS_W-1:0]  d;
    } t_plane;

    typedef struct packed {
        logic far_le;
        logic near_le;
    } t_plane_flags;

endpackage

FILE: rtl/afc_box_if.sv
// Input channel carrying one axis-aligned box per beat.
`timescale 1ns / 1ps

interface afc_box_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [afc_pkg::COORD_W-1:0]   min_x;
    logic signed [afc_pkg::COORD_W-1:0]   min_y;
    logic signed [afc_pkg::COORD_W-1:0]   min_z;
    logic signed [afc_pkg::COORD_W-1:0]   max_x;
    logic signed [afc_pkg::COORD_W-1:0]   max_y;
    logic signed [afc_pkg::COORD_W-1:0]   max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

FILE: rtl/afc_class_if.sv
// Result channel carrying one box classification per beat.
`timescale 1ns / 1ps

interface afc_class_if;
    logic       valid;
    logic       ready;
    logic [1:0] box_class;

    modport source (output valid, box_class, input ready);
    modport sink   (input valid, box_class, output ready);
endinterface

FILE: rtl/afc_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface afc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [afc_pkg::CFG_IDX_W-1:0]    index;
    logic [afc_pkg::REG_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/afc_plane_regs.sv
// Plane coefficient registers with their configuration write port.
`timescale 1ns / 1ps

module afc_plane_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    afc_cfg_if.sink         i_cfg,
    output afc_pkg::t_plane o_planes [afc_pkg::NUM_PLANES]
);
    import afc_pkg::*;

    logic [REG_W-1:0] r_coeffs [NUM_PLANES];
    logic [REG_W-1:0] n_coeffs [NUM_PLANES];

    // Writes to indexes past the tested planes match no entry and are dropped.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            n_coeffs[i] = r_coeffs[i];
            if (i_cfg.valid && (i_cfg.index == CFG_IDX_W'(i))) begin
                n_coeffs[i] = i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            if (!i_rst_n) begin
                r_coeffs[i] <= '0;
            end else begin
                r_coeffs[i] <= n_coeffs[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            o_planes[i].a = r_coeffs[i][COEF_W-1:0];
            o_planes[i].b = r_coeffs[i][B_LSB +: COEF_W];
            o_planes[i].c = r_coeffs[i][C_LSB +: COEF_W];
            o_planes[i].d = r_coeffs[i][D_LSB +: OFS_W];
        end
    end

endmodule

FILE: rtl/afc_plane_test.sv
// One plane: registered corner products, then far and near corner sign tests.
`timescale 1ns / 1ps

module afc_plane_test (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  afc_pkg::t_plane       i_plane,
    input  afc_pkg::t_box         i_box,
    output afc_pkg::t_plane_flags o_flags
);
    import afc_pkg::*;

    logic signed [COEF_W-1:0]  coef [AXES];
    logic signed [COORD_W-1:0] lo   [AXES];
    logic signed [COORD_W-1:0] hi   [AXES];

    logic signed [PROD_W-1:0]  r_prod_lo [AXES];
    logic signed [PROD_W-1:0]  r_prod_hi [AXES];
    logic signed [PROD_W-1:0]  n_prod_lo [AXES];
    logic signed [PROD_W-1:0]  n_prod_hi [AXES];
    logic [AXES-1:0]           r_pos;
    logic [AXES-1:0]           n_pos;
    logic signed [OFS_W-1:0]   r_ofs;

    logic signed [SUM_W-1:0]   far_sum;
    logic signed [SUM_W-1:0]   near_sum;

    always_comb begin
        coef[0] = i_plane.a;
        coef[1] = i_plane.b;
        coef[2] = i_plane.c;
        lo[0]   = i_box.min_x;
        lo[1]   = i_box.min_y;
        lo[2]   = i_box.min_z;
        hi[0]   = i_box.max_x;
        hi[1]   = i_box.max_y;
        hi[2]   = i_box.max_z;
        for (int k = 0; k < AXES; k++) begin
            n_prod_lo[k] = PROD_W'(coef[k]) * PROD_W'(lo[k]);
            n_prod_hi[k] = PROD_W'(coef[k]) * PROD_W'(hi[k]);
            n_pos[k]     = (coef[k] > 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_lo <= n_prod_lo;
            r_prod_hi <= n_prod_hi;
            r_pos     <= n_pos;
            r_ofs     <= i_plane.d;
        end
    end

    // A positive coefficient pushes the far corner to the max side; zero or
    // negative keeps it on the min side. The near corner is the opposite one.
    always_comb begin
        far_sum  = SUM_W'(r_ofs) <<< OFS_SHIFT;
        near_sum = SUM_W'(r_ofs) <<< OFS_SHIFT;
        for (int k = 0; k < AXES; k++) begin
            far_sum  = far_sum  + SUM_W'(r_pos[k] ? r_prod_hi[k] : r_prod_lo[k]);
            near_sum = near_sum + SUM_W'(r_pos[k] ? r_prod_lo[k] : r_prod_hi[k]);
        end
        o_flags.far_le  = far_sum[SUM_W-1]  || (far_sum == '0);
        o_flags.near_le = near_sum[SUM_W-1] || (near_sum == '0);
    end

endmodule

FILE: rtl/aabb_frustum_classifier_core.sv
// Top level: classifies axis-aligned boxes against the configured planes.
//
// Usage:
//   i_box carries one box per beat (min and max corners, 4 fraction bits).
//   o_class returns one class per box, in order: 0 outside, 1 intersecting,
//   2 fully inside.
//   i_cfg writes plane registers 0 to 5 (a, b, c in Q2.12, d in Q18.4), is
//   always ready; user writes only while no box is in flight (not enforced).
// Timing:
//   A box accepted on i_box shows its class on o_class after passing the
//   input register, product register and result register.
//   One box is taken every cycle unless o_class stalls; the rate is set by
//   the one multiplier stage per plane and axis, which is fully pipelined.
// Reset:
//   Synchronous, active low. All planes clear to zero, which makes every box
//   outside, and the pipeline empties.
// Stalls:
//   When o_class is not ready the result register holds; earlier stages keep
//   filling until each holds a box, then i_box.ready drops.
`timescale 1ns / 1ps

module aabb_frustum_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afc_box_if.sink     i_box,
    afc_class_if.source o_class,
    afc_cfg_if.sink     i_cfg
);
    import afc_pkg::*;

    t_plane       planes [NUM_PLANES];
    t_plane_flags flags  [NUM_PLANES];

    logic       r_s0_valid;
    logic       r_s1_valid;
    logic       r_out_valid;
    t_box       r_s0_box;
    t_box_class r_out_class;
    t_box_class n_out_class;

    logic en_s0;
    logic en_s1;
    logic en_out;
    logic any_far_le;
    logic any_near_le;

    afc_plane_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_planes (planes)
    );

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        afc_plane_test u_test (
            .i_clk   (i_clk),
            .i_en    (en_s1),
            .i_plane (planes[p]),
            .i_box   (r_s0_box),
            .o_flags (flags[p])
        );
    end

    // Each stage moves when it is empty or the stage after it moves.
    assign en_out      = !r_out_valid || o_class.ready;
    assign en_s1       = !r_s1_valid || en_out;
    assign en_s0       = !r_s0_valid || en_s1;
    assign i_box.ready = en_s0;

    always_comb begin
        any_far_le  = 1'b0;
        any_near_le = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            any_far_le  = any_far_le  | flags[p].far_le;
            any_near_le = any_near_le | flags[p].near_le;
        end
        if (any_far_le) begin
            n_out_class = CLASS_OUTSIDE;
        end else if (any_near_le) begin
            n_out_class = CLASS_CUT;
        end else begin
            n_out_class = CLASS_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s0) begin
                r_s0_valid <= i_box.valid;
            end
            if (en_s1) begin
                r_s1_valid <= r_s0_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0) begin
            r_s0_box.min_x <= i_box.min_x;
            r_s0_box.min_y <= i_box.min_y;
            r_s0_box.min_z <= i_box.min_z;
            r_s0_box.max_x <= i_box.max_x;
            r_s0_box.max_y <= i_box.max_y;
            r_s0_box.max_z <= i_box.max_z;
        end
        if (en_out) begin
            r_out_class <= n_out_class;
        end
    end

    assign o_class.valid     = r_out_valid;
    assign o_class.box_class = r_out_class;

`ifndef SYNTH
    a_accept_fills_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_box.valid && i_box.ready) |=> r_s0_valid)
        else $error("accepted box did not enter the input register");

    a_s0_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && en_s1) |=> r_s1_valid)
        else $error("box lost between input and product stages");

    a_s1_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && en_out) |=> r_out_valid)
        else $error("box lost between product and result stages");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> (r_s0_valid && r_s1_valid && r_out_valid))
        else $error("input stalled while the pipeline has room");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s0_valid && !r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
